// File: rtl/rgbscan_pkg.sv
// ----------------------------------------------------------------------------
// rgbscan_pkg: shared types and constants for the RGB LED scan driver
// Command codes, phase/anode codes, cathode map table and the
// control/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package rgbscan_pkg;

  localparam int LED_SLOTS    = 16;
  localparam int CHAIN_LENGTH = 16;

  localparam int LED_W = $clog2(LED_SLOTS);
  localparam int POS_W = $clog2(CHAIN_LENGTH);

  localparam int MAP_DEPTH   = 16;
  localparam int SHOWN_LIMIT = 14;

  localparam logic [7:0] NO_LED = 8'd255;

  localparam logic [7:0] CATHODE_MAP [MAP_DEPTH] = '{
    8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd255,
    8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd255
  };

  // input command codes
  localparam logic [1:0] CMD_LIGHT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR   = 2'd1;
  localparam logic [1:0] CMD_REFRESH = 2'd2;

  // colour phases, in scan order
  localparam logic [1:0] PH_RED   = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_BLUE  = 2'd2;

  // anode codes
  localparam logic [1:0] ANODE_NONE  = 2'd0;
  localparam logic [1:0] ANODE_RED   = 2'd1;
  localparam logic [1:0] ANODE_GREEN = 2'd2;
  localparam logic [1:0] ANODE_BLUE  = 2'd3;

  localparam logic [2:0] MASK_RED   = 3'b100;
  localparam logic [2:0] MASK_GREEN = 3'b010;
  localparam logic [2:0] MASK_BLUE  = 3'b001;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_LATCH
  } scan_state_t;

  typedef struct packed {
    logic wr_led;
    logic clr_all;
    logic start;
    logic emit_shift;
    logic emit_latch;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic pos_last;
    logic phase_last;
  } dp_sts_t;

  typedef struct packed {
    logic             hit;
    logic [LED_W-1:0] led;
  } led_sel_t;

  function automatic led_sel_t chain_led(input logic [POS_W-1:0] pos);
    led_sel_t   s;
    logic [7:0] m;
    s.hit = 1'b0;
    s.led = '0;
    m = CATHODE_MAP[4'(pos)];
    if (int'(pos) < MAP_DEPTH && m != NO_LED && int'(m) < SHOWN_LIMIT &&
        int'(m) < LED_SLOTS) begin
      s.hit = 1'b1;
      s.led = LED_W'(m);
    end
    return s;
  endfunction

  function automatic logic [2:0] phase_mask(input logic [1:0] phase);
    logic [2:0] m;
    unique case (phase)
      PH_RED:   m = MASK_RED;
      PH_GREEN: m = MASK_GREEN;
      PH_BLUE:  m = MASK_BLUE;
      default:  m = 3'b000;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] phase_anode(input logic [1:0] phase);
    logic [1:0] a;
    unique case (phase)
      PH_RED:   a = ANODE_RED;
      PH_GREEN: a = ANODE_GREEN;
      PH_BLUE:  a = ANODE_BLUE;
      default:  a = ANODE_NONE;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/rgb_led_shift_scan_driver_unit.sv
// ----------------------------------------------------------------------------
// rgb_led_shift_scan_driver_unit: RGB LED shift-register scan driver
// Stores a colour per LED and, on refresh, shifts out cathode bits and
// latch strobes for the red, green and blue anode phases.
// ----------------------------------------------------------------------------
// Light and clear produce no transfer and do not stall the input.
// Refresh produces 3 * (CHAIN_LENGTH + 1) = 51 transfers, one per cycle
// from the result register while out_stall is low; the accepted refresh is
// first registered in the sequencer state, then its first result in the result register.
// Input is stalled for the whole scan.
// Synchronous active-low reset clears all colours, the driven anode and the
// sequencer; no clearing pass is needed.
module rgb_led_shift_scan_driver_unit
  import rgbscan_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [3:0] in_led_index,
  input  logic [2:0] in_rgb,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_serial_data,
  output logic       out_shift_strobe,
  output logic       out_latch_strobe,
  output logic [1:0] out_anode_select,
  output logic       out_last
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  rgbscan_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  rgbscan_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_led_index     (in_led_index),
    .in_rgb           (in_rgb),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_serial_data  (out_serial_data),
    .out_shift_strobe (out_shift_strobe),
    .out_latch_strobe (out_latch_strobe),
    .out_anode_select (out_anode_select),
    .out_last         (out_last)
  );

endmodule

// File: rtl/rgbscan_ctrl.sv
// ----------------------------------------------------------------------------
// rgbscan_ctrl: scan sequencer
// Decodes commands in idle and steps the datapath through the shift and
// latch steps of the three colour phases.
// ----------------------------------------------------------------------------
module rgbscan_ctrl
  import rgbscan_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  output logic       in_stall,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd
);

  scan_state_t state_r, state_nxt;
  logic        accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_command == CMD_REFRESH) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sts.out_free && sts.pos_last) begin
          state_nxt = S_LATCH;
        end
      end
      S_LATCH: begin
        if (sts.out_free) begin
          state_nxt = sts.phase_last ? S_IDLE : S_SHIFT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_command)
            CMD_LIGHT:   cmd.wr_led  = 1'b1;
            CMD_CLEAR:   cmd.clr_all = 1'b1;
            CMD_REFRESH: cmd.start   = 1'b1;
            default:     cmd         = '0;
          endcase
        end
      end
      S_SHIFT: cmd.emit_shift = sts.out_free;
      S_LATCH: cmd.emit_latch = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/rgbscan_dp.sv
// ----------------------------------------------------------------------------
// rgbscan_dp: colour store, scan counters and result register
// Holds the per-LED colours and the driven anode, tracks chain position
// and phase, and forms each shift or latch result.
// ----------------------------------------------------------------------------
module rgbscan_dp
  import rgbscan_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  input  logic [3:0] in_led_index,
  input  logic [2:0] in_rgb,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_serial_data,
  output logic       out_shift_strobe,
  output logic       out_latch_strobe,
  output logic [1:0] out_anode_select,
  output logic       out_last
);

  logic [2:0]       colours_r [LED_SLOTS];
  logic [1:0]       active_anode_r;
  logic [POS_W-1:0] pos_r;
  logic [1:0]       phase_r;

  logic             out_valid_r, out_valid_nxt;
  logic             out_data_r, out_shift_r, out_latch_r, out_last_r;
  logic [1:0]       out_anode_r;

  led_sel_t         sel;
  logic             shift_bit;
  logic             wr_ok;
  logic [LED_W-1:0] wr_idx;
  logic [1:0]       new_anode;

  assign sel       = chain_led(pos_r);
  assign shift_bit = sel.hit && |(colours_r[sel.led] & phase_mask(phase_r));
  assign wr_ok     = int'(in_led_index) < LED_SLOTS;
  assign wr_idx    = LED_W'(in_led_index);
  assign new_anode = phase_anode(phase_r);

  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.pos_last   = (pos_r == POS_W'(CHAIN_LENGTH - 1));
  assign sts.phase_last = (phase_r == PH_BLUE);

  // colour store and driven anode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LED_SLOTS; i++) begin
        colours_r[i] <= '0;
      end
      active_anode_r <= ANODE_NONE;
    end else begin
      if (cmd.clr_all) begin
        for (int i = 0; i < LED_SLOTS; i++) begin
          colours_r[i] <= '0;
        end
      end else if (cmd.wr_led && wr_ok) begin
        colours_r[wr_idx] <= in_rgb;
      end
      if (cmd.emit_latch) begin
        active_anode_r <= new_anode;
      end
    end
  end

  // scan counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= PH_RED;
    end else begin
      if (cmd.start) begin
        pos_r   <= '0;
        phase_r <= PH_RED;
      end else if (cmd.emit_shift) begin
        pos_r <= pos_r + POS_W'(1);
      end else if (cmd.emit_latch) begin
        pos_r   <= '0;
        phase_r <= sts.phase_last ? PH_RED : phase_r + 2'd1;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_shift || cmd.emit_latch) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_shift) begin
      out_data_r  <= shift_bit;
      out_shift_r <= 1'b1;
      out_latch_r <= 1'b0;
      out_anode_r <= active_anode_r;
      out_last_r  <= 1'b0;
    end else if (cmd.emit_latch) begin
      out_data_r  <= 1'b0;
      out_shift_r <= 1'b0;
      out_latch_r <= 1'b1;
      out_anode_r <= new_anode;
      out_last_r  <= sts.phase_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_serial_data  = out_data_r;
  assign out_shift_strobe = out_shift_r;
  assign out_latch_strobe = out_latch_r;
  assign out_anode_select = out_anode_r;
  assign out_last         = out_last_r;

  // a result is only loaded when the register is empty or being taken
  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_shift || cmd.emit_latch) |-> sts.out_free)
    else $error("result loaded over an untaken result");

  // a held latch result always matches the anode now driven
  a_latch_anode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_latch_r) |-> (out_anode_r == active_anode_r))
    else $error("latch result anode differs from driven anode");

  // end of run is the blue latch
  a_last_blue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_latch_r && out_anode_r == ANODE_BLUE))
    else $error("last flag on a result other than the blue latch");

  // after any latch some anode is driven
  a_anode_on: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_latch |=> (active_anode_r != ANODE_NONE))
    else $error("no anode driven after latch");

endmodule

// File: tb/sv/rgb_led_shift_scan_driver_unit_test.sv
// ----------------------------------------------------------------------------
// rgb_led_shift_scan_driver_unit_test: regression for the RGB LED scan driver
// Drives light, clear, refresh and reserved commands, predicts every scan
// beat (cathode shifts and anode latches) and checks each output transfer
// in order, with random source idle cycles and output back-pressure.
// ----------------------------------------------------------------------------
module rgb_led_shift_scan_driver_unit_test;
  import rgbscan_pkg::*;

  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         RANDOM_CMDS  = 232;
  localparam int         DRAIN_CYCLES = 60;

  typedef struct {
    logic [1:0] command;
    logic [3:0] led_index;
    logic [2:0] rgb;
    bit         drain;     // hold off until all scan beats are back
    bit         src_idle;
    bit         snk_idle;
  } scan_cmd_t;

  typedef struct {
    logic       serial_data;
    logic       shift_strobe;
    logic       latch_strobe;
    logic [1:0] anode_select;
    logic       last;
  } scan_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_command = CMD_LIGHT;
  logic [3:0] in_led_index = '0;
  logic [2:0] in_rgb = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_serial_data;
  logic       out_shift_strobe;
  logic       out_latch_strobe;
  logic [1:0] out_anode_select;
  logic       out_last;

  rgb_led_shift_scan_driver_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_led_index     (in_led_index),
    .in_rgb           (in_rgb),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_serial_data  (out_serial_data),
    .out_shift_strobe (out_shift_strobe),
    .out_latch_strobe (out_latch_strobe),
    .out_anode_select (out_anode_select),
    .out_last         (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  scan_cmd_t  pending_cmds[$];
  scan_beat_t expected_beats[$];

  // predicted display state
  logic [2:0] model_colours [LED_SLOTS];
  logic [1:0] model_anode;

  int beats_predicted = 0;
  int beats_checked = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int n_light = 0;
  int n_clear = 0;
  int n_refresh = 0;
  int n_reserved = 0;

  bit gen_src_idle;
  bit gen_snk_idle;
  bit snk_idle = 1'b0;

  function automatic logic cathode_bit(int pos, logic [2:0] mask);
    int led;
    // chain positions 7 and 15 are unwired; 8..14 are shifted down by one
    if (pos == 7 || pos >= 15) return 1'b0;
    led = (pos < 7) ? pos : pos - 1;
    if (led >= SHOWN_LIMIT || led >= LED_SLOTS) return 1'b0;
    return |(model_colours[led] & mask);
  endfunction

  task automatic predict_scan_beats(scan_cmd_t c);
    logic [2:0] masks [3];
    logic [1:0] anodes [3];
    scan_beat_t b;
    masks  = '{MASK_RED, MASK_GREEN, MASK_BLUE};
    anodes = '{ANODE_RED, ANODE_GREEN, ANODE_BLUE};
    case (c.command)
      CMD_LIGHT: begin
        n_light++;
        if (int'(c.led_index) < LED_SLOTS) model_colours[c.led_index] = c.rgb;
      end
      CMD_CLEAR: begin
        n_clear++;
        foreach (model_colours[i]) model_colours[i] = '0;
      end
      CMD_REFRESH: begin
        n_refresh++;
        for (int ph = 0; ph < 3; ph++) begin
          for (int pos = 0; pos < CHAIN_LENGTH; pos++) begin
            b.serial_data  = cathode_bit(pos, masks[ph]);
            b.shift_strobe = 1'b1;
            b.latch_strobe = 1'b0;
            b.anode_select = model_anode;
            b.last         = 1'b0;
            expected_beats.push_back(b);
          end
          model_anode    = anodes[ph];
          b.serial_data  = 1'b0;
          b.shift_strobe = 1'b0;
          b.latch_strobe = 1'b1;
          b.anode_select = model_anode;
          b.last         = (ph == 2);
          expected_beats.push_back(b);
        end
        beats_predicted += 3 * (CHAIN_LENGTH + 1);
      end
      default: n_reserved++;
    endcase
  endtask

  // driver
  scan_cmd_t cur_cmd;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_scan_beats(cur_cmd);
        gap_left = cur_cmd.src_idle ? $urandom_range(0, 5) : 0;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].drain && beats_checked != beats_predicted)) begin
          cur_cmd = pending_cmds.pop_front();
          in_command   <= cur_cmd.command;
          in_led_index <= cur_cmd.led_index;
          in_rgb       <= cur_cmd.rgb;
          snk_idle     <= cur_cmd.snk_idle;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int stall_left = 0;

  always @(posedge clk) begin
    scan_beat_t want;
    bit         bad;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected scan transfer: data=%0b shift=%0b latch=%0b anode=%0d last=%0b",
                     out_serial_data, out_shift_strobe, out_latch_strobe,
                     out_anode_select, out_last);
        end else begin
          want = expected_beats.pop_front();
          bad  = 1'b0;
          if (out_serial_data !== want.serial_data) bad = 1'b1;
          if (out_shift_strobe !== want.shift_strobe) bad = 1'b1;
          if (out_latch_strobe !== want.latch_strobe) bad = 1'b1;
          if (out_anode_select !== want.anode_select) bad = 1'b1;
          if (out_last !== want.last) bad = 1'b1;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"beat %0d mismatch: exp data=%0b shift=%0b latch=%0b anode=%0d ",
                        "last=%0b, got data=%0b shift=%0b latch=%0b anode=%0d last=%0b"},
                       beats_checked, want.serial_data, want.shift_strobe,
                       want.latch_strobe, want.anode_select, want.last,
                       out_serial_data, out_shift_strobe, out_latch_strobe,
                       out_anode_select, out_last);
          end
          beats_checked <= beats_checked + 1;
        end
        stall_left = snk_idle ? $urandom_range(0, 5) : 0;
      end else if (snk_idle && stall_left == 0 && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding",
               cycle_count, beats_predicted - beats_checked);
      $display("rgb_led_shift_scan_driver_unit regression: fail");
      $finish;
    end
  end

  task automatic queue_cmd(logic [1:0] cmd, logic [3:0] idx, logic [2:0] rgb, bit drain);
    scan_cmd_t c;
    c.command   = cmd;
    c.led_index = idx;
    c.rgb       = rgb;
    c.drain     = drain;
    c.src_idle  = gen_src_idle;
    c.snk_idle  = gen_snk_idle;
    pending_cmds.push_back(c);
  endtask

  initial begin
    int counted;
    int pick;
    foreach (model_colours[i]) model_colours[i] = '0;
    model_anode = ANODE_NONE;

    // directed: dark refresh, extremes of index and colour, unwired slots
    gen_src_idle = 1'b1;
    gen_snk_idle = 1'b1;
    queue_cmd(CMD_REFRESH, 4'd0, 3'd0, 1'b0);
    queue_cmd(CMD_LIGHT, 4'd0, 3'd7, 1'b0);
    queue_cmd(CMD_LIGHT, 4'd15, 3'd7, 1'b0);
    queue_cmd(CMD_LIGHT, 4'd14, 3'd7, 1'b0);
    queue_cmd(CMD_LIGHT, 4'd13, 3'd5, 1'b0);
    queue_cmd(CMD_LIGHT, 4'd6, 3'd3, 1'b0);
    queue_cmd(CMD_LIGHT, 4'd7, 3'd6, 1'b0);
    queue_cmd(CMD_LIGHT, 4'd8, 3'd1, 1'b0);
    queue_cmd(CMD_LIGHT, 4'd12, 3'd2, 1'b0);
    queue_cmd(CMD_LIGHT, 4'd3, 3'd4, 1'b0);
    queue_cmd(CMD_REFRESH, 4'd15, 3'd7, 1'b0);
    queue_cmd(CMD_RESERVED, 4'd15, 3'd7, 1'b0);
    queue_cmd(CMD_REFRESH, 4'd0, 3'd0, 1'b0);
    queue_cmd(CMD_LIGHT, 4'd0, 3'd0, 1'b0);
    queue_cmd(CMD_REFRESH, 4'd5, 3'd2, 1'b1);
    queue_cmd(CMD_CLEAR, 4'd15, 3'd7, 1'b0);
    queue_cmd(CMD_REFRESH, 4'd0, 3'd0, 1'b0);
    queue_cmd(CMD_CLEAR, 4'd0, 3'd0, 1'b0);
    queue_cmd(CMD_LIGHT, 4'd9, 3'd7, 1'b0);
    queue_cmd(CMD_REFRESH, 4'd0, 3'd0, 1'b0);

    // random: lights and refreshes, mixed with clears and reserved codes;
    // idle modes rotate every quarter, each quarter opens after a full drain
    counted = 0;
    while (counted < RANDOM_CMDS) begin
      if (counted % (RANDOM_CMDS / 4) == 0) begin
        gen_src_idle = ((counted / (RANDOM_CMDS / 4)) % 2) == 0;
        gen_snk_idle = (counted / (RANDOM_CMDS / 4)) != 1 &&
                       (counted / (RANDOM_CMDS / 4)) != 2;
      end
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        queue_cmd(CMD_LIGHT, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                  counted % (RANDOM_CMDS / 4) == 0);
        counted++;
      end else if (pick < 86) begin
        queue_cmd(CMD_REFRESH, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                  counted % (RANDOM_CMDS / 4) == 0);
        counted++;
      end else if (pick < 94) begin
        queue_cmd(CMD_CLEAR, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                  counted % (RANDOM_CMDS / 4) == 0);
        counted++;
      end else begin
        queue_cmd(CMD_RESERVED, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                  1'b0);
      end
    end
    queue_cmd(CMD_REFRESH, 4'd0, 3'd0, 1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid || beats_checked != beats_predicted)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("commands: %0d light, %0d clear, %0d refresh, %0d reserved",
             n_light, n_clear, n_refresh, n_reserved);
    $display("scan beats checked: %0d of %0d, mismatches: %0d",
             beats_checked, beats_predicted, mismatches);
    if (mismatches == 0 && beats_checked == beats_predicted)
      $display("rgb_led_shift_scan_driver_unit regression: pass");
    else
      $display("rgb_led_shift_scan_driver_unit regression: fail");
    $finish;
  end

endmodule
